[sv/pcmhg_pkg.sv]
`timescale 1ns / 1ps
package pcmhg_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;
    localparam int DIV_N      = 34;
    localparam int CS_W       = 31;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_BAD_RD  = 2'd3;

    localparam logic [2:0] CFG_X_MIN = 3'd0;
    localparam logic [2:0] CFG_X_MAX = 3'd1;
    localparam logic [2:0] CFG_Y_MIN = 3'd2;
    localparam logic [2:0] CFG_Y_MAX = 3'd3;
    localparam logic [2:0] CFG_Z_MIN = 3'd4;
    localparam logic [2:0] CFG_Z_MAX = 3'd5;
    localparam logic [2:0] CFG_CELL  = 3'd6;

    typedef struct packed {
        logic [15:0]        count;
        logic signed [31:0] height;
        logic               occupied;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);
endpackage

[sv/pcmhg_ram.sv]
`timescale 1ns / 1ps
module pcmhg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/pcmhg_div.sv]
`timescale 1ns / 1ps
module pcmhg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcmhg_pkg::DIV_N-1:0]   i_dividend,
    input  logic [pcmhg_pkg::CS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [pcmhg_pkg::DIV_N-1:0]   o_quot
);
    import pcmhg_pkg::*;

    logic [DIV_N-1:0] r_q, n_q;
    logic [CS_W-1:0]  r_rem, n_rem, r_dv;
    logic [5:0]       r_cnt;
    logic             r_busy, r_done;
    logic [CS_W:0]    w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[DIV_N-1]};
    assign w_ge    = w_trial >= {1'b0, r_dv};

    always_comb begin
        n_rem = w_ge ? CS_W'(w_trial - {1'b0, r_dv}) : w_trial[CS_W-1:0];
        n_q   = {r_q[DIV_N-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[sv/point_cloud_max_height_gridder.sv]
`timescale 1ns / 1ps
// Max-height point gridder. After reset the cell store is cleared one entry a cycle, all
// 65536 entries, with s_axis_tready low (configuration writes are taken). Each transaction
// is then handled alone: a bit-serial divider derives grid width and height, and for a
// kept point also column and row. A kept point and an in-grid read both read the cell
// word, and a kept point then writes it back. A result that is not taken holds the next
// result in the block until it is.
module point_cloud_max_height_gridder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // point_x, point_y, point_z, red_in, green_in, blue_in, read_column, read_row
    input  logic [135:0] i_s_axis_tdata,
    // req_type, colour_present
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // cell_count, cell_height, height_valid, red_out, green_out, blue_out, pad
    output logic [79:0]  o_m_axis_tdata,
    // status
    output logic [1:0]   o_m_axis_tuser
);
    import pcmhg_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV_W = 4'd2;
    localparam logic [3:0] S_DIV_H = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_DIV_C = 4'd5;
    localparam logic [3:0] S_DIV_R = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_MOD   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic signed [31:0] r_x_min, r_x_max, r_y_min, r_y_max, r_z_min, r_z_max;
    logic [CS_W-1:0]    r_cs;
    logic [CS_W-1:0]    w_cs;

    logic [3:0]         r_state;
    logic [ADDR_W-1:0]  r_clr;
    logic               r_req, r_cp;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [7:0]         r_r, r_g, r_b, r_rc, r_rr;
    logic [DIM_W-1:0]   r_w, r_h, r_col;
    logic               r_big;
    logic [ADDR_W-1:0]  r_addr;
    logic [1:0]         r_res_st;
    t_cell              r_res;
    logic               r_ov;
    logic [1:0]         r_ost;
    t_cell              r_ocell;

    logic               w_start;
    logic [DIV_N-1:0]   w_dividend, w_quot;
    logic               w_done;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_cell              w_wcell, w_rcell, w_new;
    logic [CELL_W-1:0]  w_rdata;
    logic               w_in_acc, w_inside, w_upd;
    logic [DIM_W-1:0]   w_dim, w_qd, w_clamp;
    logic               w_dim_big;
    logic signed [31:0] w_lo, w_hi;
    logic [32:0]        w_span;
    logic               w_x_neg, w_y_neg;

    assign w_cs = (r_cs == '0) ? CS_W'(1) : r_cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_x_max <= '0;
            r_y_min <= '0;
            r_y_max <= '0;
            r_z_min <= '0;
            r_z_max <= '0;
            r_cs    <= CS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_X_MIN: r_x_min <= i_cfg_data;
                CFG_X_MAX: r_x_max <= i_cfg_data;
                CFG_Y_MIN: r_y_min <= i_cfg_data;
                CFG_Y_MAX: r_y_max <= i_cfg_data;
                CFG_Z_MIN: r_z_min <= i_cfg_data;
                CFG_Z_MAX: r_z_max <= i_cfg_data;
                CFG_CELL:  r_cs    <= i_cfg_data[CS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_x_neg = (r_x_max < r_x_min);
    assign w_y_neg = (r_y_max < r_y_min);

    // dividend selection for the shared divider
    always_comb begin
        w_lo = (r_state == S_IDLE) ? r_x_min : r_y_min;
        w_hi = (r_state == S_IDLE) ? r_x_max : r_y_max;
        w_span = 33'({w_hi[31], w_hi} - {w_lo[31], w_lo});
        unique case (r_state)
            S_CHECK: w_dividend = DIV_N'(33'({r_px[31], r_px} - {r_x_min[31], r_x_min}));
            S_DIV_C: w_dividend = DIV_N'(33'({r_y_max[31], r_y_max} - {r_py[31], r_py}));
            default: w_dividend = w_span[32] ? '0 :
                                  DIV_N'(DIV_N'(w_span[31:0]) + DIV_N'(w_cs) - DIV_N'(1));
        endcase
    end

    assign w_inside = (r_px >= r_x_min) && (r_px <= r_x_max) && (r_py >= r_y_min) &&
                      (r_py <= r_y_max) && (r_pz >= r_z_min) && (r_pz <= r_z_max);

    assign w_start = w_in_acc || ((r_state == S_DIV_W) && w_done) ||
                     ((r_state == S_CHECK) && !r_big && !r_req && w_inside) ||
                     ((r_state == S_DIV_C) && w_done);

    pcmhg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_cs),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    // grid dimension from quotient; a negative span gives zero
    always_comb begin
        w_dim_big = 1'b0;
        if ((r_state == S_DIV_W) ? w_x_neg : w_y_neg) begin
            w_dim = '0;
        end else if (w_quot == '0) begin
            w_dim = DIM_W'(1);
        end else begin
            w_dim     = w_quot[DIM_W-1:0];
            w_dim_big = (r_state == S_DIV_W) ? (w_quot > DIV_N'(MAX_WIDTH)) :
                                               (w_quot > DIV_N'(MAX_HEIGHT));
        end
        w_qd    = w_quot[DIM_W-1:0];
        w_clamp = (w_qd >= r_h) ? DIM_W'(r_h - DIM_W'(1)) : w_qd;
    end

    assign w_rcell = t_cell'(w_rdata);

    always_comb begin
        w_new = w_rcell;
        w_upd = !w_rcell.occupied || (r_pz > w_rcell.height);
        if (w_rcell.count != 16'hFFFF) begin
            w_new.count = w_rcell.count + 16'd1;
        end
        if (w_upd) begin
            w_new.height   = r_pz;
            w_new.occupied = 1'b1;
            if (r_cp) begin
                w_new.red   = r_r;
                w_new.green = r_g;
                w_new.blue  = r_b;
            end
        end
    end

    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_MOD) && !r_req);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign w_wcell = (r_state == S_CLEAR) ? t_cell'('0) : w_new;

    pcmhg_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wcell),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_ov || i_m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE:  if (w_in_acc) r_state <= S_DIV_W;
                S_DIV_W: if (w_done) r_state <= S_DIV_H;
                S_DIV_H: if (w_done) r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_big || r_req || !w_inside) begin
                        r_state <= (!r_big && r_req && (DIM_W'(r_rc) < r_w) &&
                                    (DIM_W'(r_rr) < r_h)) ? S_RD : S_FIN;
                    end else begin
                        r_state <= S_DIV_C;
                    end
                end
                S_DIV_C: if (w_done) r_state <= S_DIV_R;
                S_DIV_R: if (w_done) r_state <= S_RD;
                S_RD:    r_state <= S_MOD;
                S_MOD:   r_state <= S_FIN;
                S_FIN: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_s_axis_tuser[0];
            r_cp  <= i_s_axis_tuser[1];
            r_px  <= i_s_axis_tdata[31:0];
            r_py  <= i_s_axis_tdata[63:32];
            r_pz  <= i_s_axis_tdata[95:64];
            r_r   <= i_s_axis_tdata[103:96];
            r_g   <= i_s_axis_tdata[111:104];
            r_b   <= i_s_axis_tdata[119:112];
            r_rc  <= i_s_axis_tdata[127:120];
            r_rr  <= i_s_axis_tdata[135:128];
        end
        if ((r_state == S_DIV_W) && w_done) begin
            r_w   <= w_dim;
            r_big <= w_dim_big;
        end
        if ((r_state == S_DIV_H) && w_done) begin
            r_h   <= w_dim;
            r_big <= r_big || w_dim_big;
        end
        if (r_state == S_CHECK) begin
            r_res <= '0;
            r_addr <= {r_rr[ROW_W-1:0], r_rc[COL_W-1:0]};
            if (r_big) begin
                r_res_st <= ST_TOO_BIG;
            end else if (r_req) begin
                r_res_st <= ((DIM_W'(r_rc) < r_w) && (DIM_W'(r_rr) < r_h)) ? ST_OK : ST_BAD_RD;
            end else begin
                r_res_st <= w_inside ? ST_OK : ST_OUTSIDE;
            end
        end
        if ((r_state == S_DIV_C) && w_done) begin
            r_col <= (w_qd >= r_w) ? DIM_W'(r_w - DIM_W'(1)) : w_qd;
        end
        if ((r_state == S_DIV_R) && w_done) begin
            r_addr <= {w_clamp[ROW_W-1:0], r_col[COL_W-1:0]};
        end
        if (r_state == S_MOD) begin
            r_res <= r_req ? w_rcell : w_new;
        end
        if ((r_state == S_FIN) && (!r_ov || i_m_axis_tready)) begin
            r_ost   <= r_res_st;
            r_ocell <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_ost;
    assign o_m_axis_tdata  = {7'd0, r_ocell.blue, r_ocell.green, r_ocell.red,
                              r_ocell.occupied, r_ocell.height, r_ocell.count};

`ifndef SYNTHESIS
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_m_axis_tvalid)
        else $error("result during clearing pass");
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_OK)) |-> (r_ocell == '0))
        else $error("error result carries cell data");
    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && (r_state != S_CLEAR)) |-> (r_res_st == ST_OK))
        else $error("store written for rejected transaction");
    a_mod_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> ($past(r_state) == S_RD))
        else $error("modify without read");
`endif
endmodule

[bench/point_cloud_max_height_gridder_tb.sv]
`timescale 1ns / 1ps
module point_cloud_max_height_gridder_tb;
    import pcmhg_pkg::*;

    localparam int IDLE_LIMIT = 300000;
    localparam int SETTLE     = 400;

    typedef struct {
        logic        is_read;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        has_colour;
        logic [7:0]  rd_col;
        logic [7:0]  rd_row;
    } t_req;

    typedef struct {
        logic [1:0] status;
        t_cell      entry;
    } t_outcome;

    class gridder_scoreboard;
        longint     x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
        longint     cell_len;
        logic [15:0] counts[DEPTH];
        logic [31:0] heights[DEPTH];
        logic        occupied[DEPTH];
        logic [23:0] colours[DEPTH];
        t_outcome    pending_cells[$];
        int          errors;
        int          checked;
        int          n_ok, n_outside, n_big, n_badrd;

        function new();
            x_lo = 0; x_hi = 0; y_lo = 0; y_hi = 0; z_lo = 0; z_hi = 0;
            cell_len = 1;
            foreach (counts[i]) begin
                counts[i] = '0; heights[i] = '0; occupied[i] = 1'b0; colours[i] = '0;
            end
            errors = 0; checked = 0;
            n_ok = 0; n_outside = 0; n_big = 0; n_badrd = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_X_MIN: x_lo = longint'($signed(v));
                CFG_X_MAX: x_hi = longint'($signed(v));
                CFG_Y_MIN: y_lo = longint'($signed(v));
                CFG_Y_MAX: y_hi = longint'($signed(v));
                CFG_Z_MIN: z_lo = longint'($signed(v));
                CFG_Z_MAX: z_hi = longint'($signed(v));
                CFG_CELL:  cell_len = longint'(v[30:0]);
                default: ;
            endcase
        endfunction

        function longint eff_cell();
            return cell_len == 0 ? 1 : cell_len;
        endfunction

        function longint dim(longint lo, longint hi);
            longint n;
            if (hi < lo) return 0;
            n = (hi - lo + eff_cell() - 1) / eff_cell();
            return n == 0 ? 1 : n;
        endfunction

        function t_cell cell_at(int a);
            t_cell c;
            c.count = counts[a];
            c.height = heights[a];
            c.occupied = occupied[a];
            {c.red, c.green, c.blue} = colours[a];
            return c;
        endfunction

        function void note_request(t_req r);
            t_outcome o;
            longint w, h, x, y, z, col, row;
            int a;
            w = dim(x_lo, x_hi);
            h = dim(y_lo, y_hi);
            o.status = ST_OK;
            o.entry = '0;
            if (w > MAX_WIDTH || h > MAX_HEIGHT) begin
                o.status = ST_TOO_BIG;
            end else if (r.is_read) begin
                if (r.rd_col >= w || r.rd_row >= h) o.status = ST_BAD_RD;
                else o.entry = cell_at(int'(r.rd_row) * MAX_WIDTH + int'(r.rd_col));
            end else begin
                x = longint'($signed(r.px));
                y = longint'($signed(r.py));
                z = longint'($signed(r.pz));
                if (x < x_lo || x > x_hi || y < y_lo || y > y_hi || z < z_lo || z > z_hi) begin
                    o.status = ST_OUTSIDE;
                end else begin
                    col = (x - x_lo) / eff_cell();
                    row = (y_hi - y) / eff_cell();
                    if (col >= w) col = w - 1;
                    if (row >= h) row = h - 1;
                    a = int'(row) * MAX_WIDTH + int'(col);
                    if (counts[a] != 16'hffff) counts[a]++;
                    if (!occupied[a] || z > longint'($signed(heights[a]))) begin
                        heights[a] = r.pz;
                        occupied[a] = 1'b1;
                        if (r.has_colour) colours[a] = {r.red, r.green, r.blue};
                    end
                    o.entry = cell_at(a);
                end
            end
            case (o.status)
                ST_OK:      n_ok++;
                ST_OUTSIDE: n_outside++;
                ST_TOO_BIG: n_big++;
                default:    n_badrd++;
            endcase
            pending_cells.push_back(o);
        endfunction

        task report(string what, logic [79:0] got, logic [79:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [1:0] status, logic [79:0] data);
            t_outcome o;
            checked++;
            if (pending_cells.size() == 0) begin
                report("unexpected transaction", data, '0);
                return;
            end
            o = pending_cells.pop_front();
            if (status != o.status) report("status", 80'(status), 80'(o.status));
            if (data[15:0] != o.entry.count)
                report("count", 80'(data[15:0]), 80'(o.entry.count));
            if (data[47:16] != o.entry.height)
                report("height", 80'(data[47:16]), 80'(unsigned'(o.entry.height)));
            if (data[48] != o.entry.occupied)
                report("height_valid", 80'(data[48]), 80'(o.entry.occupied));
            if (data[56:49] != o.entry.red)
                report("red", 80'(data[56:49]), 80'(o.entry.red));
            if (data[64:57] != o.entry.green)
                report("green", 80'(data[64:57]), 80'(o.entry.green));
            if (data[72:65] != o.entry.blue)
                report("blue", 80'(data[72:65]), 80'(o.entry.blue));
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // point_x, point_y, point_z, red_in, green_in, blue_in, read_column, read_row
    logic [135:0] i_s_axis_tdata = '0;
    // req_type, colour_present
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // cell_count, cell_height, height_valid, red_out, green_out, blue_out, pad
    logic [79:0]  o_m_axis_tdata;
    // status
    logic [1:0]   o_m_axis_tuser;

    gridder_scoreboard grid_sb = new();
    int rcv_mode = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int phases = 0;
    t_req req_log[$];

    point_cloud_max_height_gridder u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        case (rcv_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            default: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            grid_sb.note_request(req_log.pop_front());
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            grid_sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("point_cloud_max_height_gridder_tb: done, errors");
            $finish;
        end
    end

    task write_config(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl, logic [31:0] yh,
                      logic [31:0] zl, logic [31:0] zh, logic [31:0] cs);
        logic [31:0] vals[7];
        logic [2:0]  addrs[7];
        vals = '{xl, xh, yl, yh, zl, zh, cs};
        addrs = '{CFG_X_MIN, CFG_X_MAX, CFG_Y_MIN, CFG_Y_MAX, CFG_Z_MIN, CFG_Z_MAX, CFG_CELL};
        for (int i = 0; i < 7; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_addr <= addrs[i];
            i_cfg_data <= vals[i];
            grid_sb.set_reg(addrs[i], vals[i]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task send(t_req r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
        req_log.push_back(r);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {r.rd_row, r.rd_col, r.blue, r.green, r.red, r.pz, r.py, r.px};
        i_s_axis_tuser <= {r.has_colour, r.is_read};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task drain();
        i_s_axis_tvalid <= 1'b0;
        while (grid_sb.pending_cells.size() != 0 || req_log.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_req noise_req();
        t_req r;
        r.is_read = 1'($urandom_range(0, 1));
        r.px = $urandom; r.py = $urandom; r.pz = $urandom;
        {r.red, r.green, r.blue} = 24'($urandom);
        r.has_colour = 1'($urandom_range(0, 1));
        r.rd_col = 8'($urandom); r.rd_row = 8'($urandom);
        return r;
    endfunction

    function automatic longint pick(longint lo, longint hi);
        longint span;
        if (hi < lo) return lo;
        span = hi - lo + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_req point_req(longint x, longint y, longint z);
        t_req r;
        r = noise_req();
        r.is_read = 1'b0;
        r.px = x[31:0]; r.py = y[31:0]; r.pz = z[31:0];
        return r;
    endfunction

    function automatic t_req read_req(int c, int rw);
        t_req r;
        r = noise_req();
        r.is_read = 1'b1;
        r.rd_col = c[7:0]; r.rd_row = rw[7:0];
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        longint cs, xl, xh, yl, yh, hot;
        int sel;
        cs = grid_sb.eff_cell();
        sel = $urandom_range(0, 99);
        if (sel < 10 || grid_sb.x_hi < grid_sb.x_lo || grid_sb.y_hi < grid_sb.y_lo)
            return noise_req();
        if (sel < 30) begin
            if ($urandom_range(0, 1)) return read_req($urandom_range(0, 3), $urandom_range(0, 3));
            return read_req($urandom_range(0, int'(grid_sb.dim(grid_sb.x_lo, grid_sb.x_hi))),
                            $urandom_range(0, int'(grid_sb.dim(grid_sb.y_lo, grid_sb.y_hi))));
        end
        xl = grid_sb.x_lo; xh = grid_sb.x_hi; yl = grid_sb.y_lo; yh = grid_sb.y_hi;
        if (sel < 65) begin
            hot = 4 * cs - 1;
            if (xh > xl + hot) xh = xl + hot;
            if (yl < yh - hot) yl = yh - hot;
        end else if (sel < 72) begin
            xl = xh;
        end else if (sel < 79) begin
            yh = yl;
        end
        r = point_req(pick(xl, xh), pick(yl, yh),
                      $urandom_range(0, 9) == 0 ? longint'($signed($urandom))
                                                : pick(grid_sb.z_lo, grid_sb.z_hi));
        return r;
    endfunction

    task random_config();
        longint cs, xl, xh, yl, yh, zl, zh;
        case ($urandom_range(0, 4))
            0: cs = $urandom_range(1, 8);
            1: cs = $urandom_range(1, 5000);
            2: cs = longint'($urandom & 32'h7fffffff);
            3: cs = 0;
            default: cs = 64'sd2147483647;
        endcase
        xl = longint'($signed($urandom));
        yl = longint'($signed($urandom));
        if ($urandom_range(0, 1)) begin
            xl = xl / 65536; yl = yl / 65536;
        end
        xh = clamp32(xl + (cs == 0 ? 1 : cs) * $urandom_range(0, 270) - $urandom_range(0, 3));
        yh = clamp32(yl + (cs == 0 ? 1 : cs) * $urandom_range(0, 270) - $urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) xh = xl - 1;
        zl = longint'($signed($urandom)) / ($urandom_range(0, 1) ? 1 : 65536);
        zh = clamp32(zl + longint'($urandom));
        write_config(xl[31:0], xh[31:0], yl[31:0], yh[31:0], zl[31:0], zh[31:0], cs[31:0]);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default grid is one cell at the origin
        send(point_req(0, 0, 0));
        send(read_req(0, 0));
        send(read_req(1, 0));
        send(point_req(1, 0, 0));
        drain();

        write_config(32'd0, 32'd1000, 32'd0, 32'd1000, -32'sd100, 32'd100000, 32'd4);
        begin
            t_req r;
            r = point_req(0, 1000, 5); r.has_colour = 1'b1; send(r);
            r = point_req(3, 997, 50); r.has_colour = 1'b0; send(r);
            r = point_req(1, 999, 50); r.has_colour = 1'b1; send(r);
            r = point_req(2, 998, -100); r.has_colour = 1'b1; send(r);
            send(point_req(1000, 0, 100000));
            send(point_req(1001, 0, 0));
            send(point_req(0, 0, -101));
            send(read_req(0, 0));
            send(read_req(249, 249));
            send(read_req(250, 0));
            send(read_req(255, 255));
        end
        drain();

        rcv_mode = 2;
        write_config(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send(point_req(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648));
        send(point_req(64'sd2147483647, -64'sd2147483648, 64'sd2147483647));
        send(read_req(2, 2));
        drain();

        write_config(32'd0, 32'd1000, 32'd0, 32'd10, 32'd0, 32'd10, 32'd1);
        send(point_req(5, 5, 5));
        send(read_req(0, 0));
        drain();

        write_config(32'd0, 32'd10, 32'd0, 32'd10, 32'd0, 32'd10, 32'd0);
        send(point_req(10, 0, 10));
        drain();
        write_config(32'd5, 32'd4, 32'd0, 32'd10, 32'd0, 32'd10, 32'd1);
        drain();
        send(point_req(5, 5, 5));
        send(read_req(0, 0));
        drain();

        for (phases = 0; phases < 13; phases++) begin
            rcv_mode = phases % 3;
            random_config();
            for (int i = 0; i < 100; i++) send(random_req());
            drain();
        end

        $display("checked %0d results over %0d box settings", grid_sb.checked, phases + 6);
        $display("%0d ok, %0d outside, %0d too big, %0d bad read",
                 grid_sb.n_ok, grid_sb.n_outside, grid_sb.n_big, grid_sb.n_badrd);
        if (grid_sb.errors == 0 && grid_sb.pending_cells.size() == 0)
            $display("point_cloud_max_height_gridder_tb: done, clean");
        else
            $display("point_cloud_max_height_gridder_tb: done, errors");
        $finish;
    end
endmodule
